### src/int64_to_double_convert_assert.svh
// Assertion macros shared by the checker.
`ifndef INT64_TO_DOUBLE_CONVERT_ASSERT_SVH
`define INT64_TO_DOUBLE_CONVERT_ASSERT_SVH
// Assert that a condition implies a result in the same cycle.
`define I2D_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert that a condition implies a result in the next cycle.
`define I2D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### src/i2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2d_pkg;
	localparam int FracBits = 52;
	localparam int ExpBias  = 1023;

	localparam logic [1:0] RM_NEAREST = 2'd0;
	localparam logic [1:0] RM_ZERO    = 2'd1;
	localparam logic [1:0] RM_UP      = 2'd2;
	localparam logic [1:0] RM_DOWN    = 2'd3;

	// Stage 1 to stage 2: magnitude, sign, zero flag and captured mode.
	typedef struct packed {
		logic        neg;
		logic        zero;
		logic [1:0]  mode;
		logic [63:0] mag;
	} mag_t;

	// Stage 2 to stage 3: normalised magnitude, top bit set unless zero.
	typedef struct packed {
		logic        neg;
		logic        zero;
		logic [1:0]  mode;
		logic [5:0]  msb;
		logic [63:0] norm;
	} norm_t;

	// Stage 3 to stage 4: rounding decision made.
	typedef struct packed {
		logic        neg;
		logic        zero;
		logic        up;
		logic        inexact;
		logic [5:0]  msb;
		logic [52:0] sig;
	} rnd_t;
endpackage
`default_nettype wire

### src/i2d_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// Leading-one search and left alignment of the magnitude.
module i2d_norm (
	input  var i2d_pkg::mag_t  mag,
	output var i2d_pkg::norm_t norm
);
	logic [5:0] lz;

	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (mag.mag[i]) begin
				lz = 6'(63 - i);
			end
		end
		norm.neg  = mag.neg;
		norm.zero = mag.zero;
		norm.mode = mag.mode;
		norm.msb  = 6'd63 - lz;
		norm.norm = mag.mag << lz;
	end
endmodule
`default_nettype wire

### src/i2d_round.sv
`timescale 1ns / 1ps
`default_nettype none
// Round the aligned significand by the selected mode.
module i2d_round (
	input  var i2d_pkg::norm_t norm,
	output var i2d_pkg::rnd_t  rnd
);
	logic       lsb, rbit, sticky, inx;
	logic       up;

	always_comb begin
		lsb    = norm.norm[11];
		rbit   = norm.norm[10];
		sticky = |norm.norm[9:0];
		inx    = rbit | sticky;
		case (norm.mode)
			i2d_pkg::RM_NEAREST: up = rbit & (sticky | lsb);
			i2d_pkg::RM_UP:      up = inx & ~norm.neg;
			i2d_pkg::RM_DOWN:    up = inx & norm.neg;
			default:             up = 1'b0;
		endcase
		rnd.neg     = norm.neg;
		rnd.zero    = norm.zero;
		rnd.up      = up;
		rnd.inexact = inx;
		rnd.msb     = norm.msb;
		rnd.sig     = norm.norm[63:11];
	end
endmodule
`default_nettype wire

### src/int64_to_double_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Signals                        | Direction
// request  | in_valid, in_ready, int_value  | in
// result   | out_valid, out_ready,          | out
//          |   double_bits, inexact         |
// config   | cfg_we, cfg_wdata              | in
//
// Four register stages: magnitude, normalise, round, pack/output.
// One request enters every cycle while no stall at the output holds the pipe.
// arst_n clears the valid bits and the rounding mode at once.
// A stall at the output holds every stage that is full; a stage with an
// empty slot ahead still advances, so bubbles are squeezed out.
module int64_to_double_convert (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        cfg_we,
	input  var logic [1:0]  cfg_wdata,
	input  var logic        in_valid,
	output var logic        in_ready,
	input  var logic [63:0] int_value,
	output var logic        out_valid,
	input  var logic        out_ready,
	output var logic [63:0] double_bits,
	output var logic        inexact
);
	logic [1:0] mode_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;
	i2d_pkg::mag_t  m_s1;
	i2d_pkg::norm_t n_d, n_s2;
	i2d_pkg::rnd_t  r_d, r_s3;
	logic [63:0] bits_s4;
	logic        inx_s4;
	logic [52:0] sig_r;
	logic [10:0] exp_r;
	logic [63:0] mag_d;

	// Each stage advances when its successor is empty or advancing.
	assign adv4 = ~v_s4 | out_ready;
	assign adv3 = ~v_s3 | adv4;
	assign adv2 = ~v_s2 | adv3;
	assign adv1 = ~v_s1 | adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= i2d_pkg::RM_NEAREST;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Unsigned negation: the most negative value yields 2^63 directly.
	assign mag_d = int_value[63] ? (64'd0 - int_value) : int_value;

	i2d_norm u_norm (.mag(m_s1), .norm(n_d));
	i2d_round u_round (.norm(n_s2), .rnd(r_d));

	// Carry out of rounding bumps the exponent; significand wraps to zero.
	always_comb begin
		sig_r = r_s3.sig + 53'(r_s3.up);
		exp_r = 11'(r_s3.msb) + 11'(i2d_pkg::ExpBias);
		if (r_s3.up && sig_r == 53'd0) begin
			exp_r = exp_r + 11'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			m_s1.neg  <= int_value[63];
			m_s1.zero <= int_value == 64'd0;
			m_s1.mode <= mode_q;
			m_s1.mag  <= mag_d;
		end
		if (adv2 && v_s1) n_s2 <= n_d;
		if (adv3 && v_s2) r_s3 <= r_d;
		if (adv4 && v_s3) begin
			if (r_s3.zero) begin
				bits_s4 <= 64'd0;
				inx_s4  <= 1'b0;
			end else begin
				bits_s4 <= {r_s3.neg, exp_r, sig_r[51:0]};
				inx_s4  <= r_s3.inexact;
			end
		end
	end

	assign out_valid   = v_s4;
	assign double_bits = bits_s4;
	assign inexact     = inx_s4;
endmodule
`default_nettype wire

### src/i2d_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "int64_to_double_convert_assert.svh"
// Port-level checks on the converter.
module i2d_checker (
	input var logic        clk,
	input var logic        arst_n,
	input var logic        in_valid,
	input var logic        in_ready,
	input var logic        out_valid,
	input var logic        out_ready,
	input var logic [63:0] double_bits,
	input var logic        inexact
);
	`I2D_ASSERT_IMP(a_ready_when_drained, !out_valid && $past(!out_valid), in_ready)
	`I2D_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(double_bits))
	`I2D_ASSERT_IMP(a_zero_exact, out_valid && double_bits == 64'd0, !inexact)
endmodule
bind int64_to_double_convert i2d_checker u_chk (.*);
`default_nettype wire

### tb/tb_int64_to_double_convert.sv
`timescale 1ns / 1ps

// Holds the conversions still owed by the block, oldest first, and
// compares each result against the head of that list.
class conversion_scoreboard;
	logic [63:0] owed_bits[$];
	logic        owed_inexact[$];
	int          mismatches;
	int          checked;

	function new();
		mismatches = 0;
		checked = 0;
	endfunction

	// Convert one integer under the given rounding mode and note the result.
	function void note_request(logic [63:0] x, logic [1:0] mode);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] sig;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] bits;
		logic [10:0] expo;
		int          msb;
		int          shift;
		logic        up;
		neg = x[63];
		mag = neg ? (64'd0 - x) : x;
		rem = 64'd0;
		up = 1'b0;
		if (mag == 64'd0) begin
			owed_bits.push_back(64'd0);
			owed_inexact.push_back(1'b0);
			return;
		end
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (mag[i])
				msb = i;
		expo = 11'(msb + i2d_pkg::ExpBias);
		if (msb <= i2d_pkg::FracBits) begin
			sig = mag << (i2d_pkg::FracBits - msb);
		end else begin
			shift = msb - i2d_pkg::FracBits;
			sig = mag >> shift;
			rem = mag & ((64'd1 << shift) - 64'd1);
			half = 64'd1 << (shift - 1);
			case (mode)
				i2d_pkg::RM_NEAREST: up = (rem > half) || (rem == half && sig[0]);
				i2d_pkg::RM_UP:      up = (rem != 0) && !neg;
				i2d_pkg::RM_DOWN:    up = (rem != 0) && neg;
				default:             up = 1'b0;
			endcase
			if (up) begin
				sig = sig + 64'd1;
				// carry out of the significand: renormalise
				if (sig[53]) begin
					sig = sig >> 1;
					expo = expo + 11'd1;
				end
			end
		end
		bits = {neg, expo, sig[51:0]};
		owed_bits.push_back(bits);
		owed_inexact.push_back(rem != 0);
	endfunction

	function void check_result(logic [63:0] bits, logic inex);
		checked++;
		if (owed_bits.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h inexact %b", bits, inex);
			return;
		end
		if (bits !== owed_bits[0] || inex !== owed_inexact[0]) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected %h/%b, got %h/%b",
					owed_bits[0], owed_inexact[0], bits, inex);
		end
		void'(owed_bits.pop_front());
		void'(owed_inexact.pop_front());
	endfunction
endclass

module tb_int64_to_double_convert;
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 12;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] int_value;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] double_bits;
	logic        inexact;

	conversion_scoreboard board;
	logic [1:0] mode_now;
	int         send_idle_pct;
	int         stall_pct;
	int         sent;
	int         cycles;
	int         modes_seen;

	int64_to_double_convert dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.int_value  (int_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.double_bits(double_bits),
		.inexact    (inexact)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Abort on a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Sample results on the rising edge; the stall pattern changes only at
	// the falling edge so the sampled ready is always settled.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_result(double_bits, inexact);

	always @(negedge clk)
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);

	// Present one request and hold it until the block takes it; valid
	// drops only while the sender idles, so requests can follow back to back.
	task automatic send_request(logic [63:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		int_value <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_request(x, mode_now);
		sent++;
		@(negedge clk);
	endtask

	// Let the pipe empty, then write the rounding mode while idle.
	task automatic set_mode(logic [1:0] mode);
		in_valid <= 1'b0;
		while (board.owed_bits.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_now = mode;
		modes_seen++;
	endtask

	// Random integer biased towards every magnitude band and the
	// boundaries where rounding carries or ties.
	function automatic logic [63:0] random_int();
		logic [63:0] v;
		int          width;
		v = {$urandom, $urandom};
		width = $urandom_range(64, 1);
		case ($urandom_range(5))
			0: v = v;
			1: v = v >> (64 - width);
			2: v = ((64'd1 << $urandom_range(63, 53)) - 64'd1);
			3: v = ((64'd1 << $urandom_range(62, 54)) | (64'd1 << $urandom_range(10)));
			4: v = 64'd0 - (v >> (64 - width));
			default: v = {1'b1, 53'd0, 10'(v)};
		endcase
		return v;
	endfunction

	task automatic run_random(int count, int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			send_request(random_int());
	endtask

	initial begin
		logic [63:0] edges[$];
		board = new();
		mode_now = i2d_pkg::RM_NEAREST;
		cycles = 0;
		sent = 0;
		modes_seen = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = i2d_pkg::RM_NEAREST;
		in_valid = 1'b0;
		int_value = 64'd0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero, one, ten, the extremes, the first inexact band, exact ties
		// and an all-ones significand that carries into the exponent.
		edges = '{64'd0, 64'd1, 64'd10, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h0020_0000_0000_0000, 64'h0020_0000_0000_0001,
			64'h0020_0000_0000_0003, 64'h0040_0000_0000_0002,
			64'h003F_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
			64'hFFDF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0400,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
		for (int m = 0; m < 4; m++) begin
			set_mode(2'(m));
			foreach (edges[i])
				send_request(edges[i]);
		end

		// Four random phases, each under a fresh rounding mode and its own mix of idling and stalls.
		set_mode(i2d_pkg::RM_NEAREST);
		run_random(150, 0, 0);
		set_mode(i2d_pkg::RM_UP);
		run_random(150, 71, 0);
		set_mode(i2d_pkg::RM_DOWN);
		run_random(150, 0, 71);
		set_mode(i2d_pkg::RM_ZERO);
		run_random(150, 13, 13);

		in_valid <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		while (board.owed_bits.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("converted %0d integers over %0d rounding-mode settings, %0d results checked",
			sent, modes_seen, board.checked);
		if (board.mismatches == 0 && board.owed_bits.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
